// File: design/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Types and codes shared by the max stack engine modules.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned WordW = 32;

  // operation codes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_POPMAX = 2'd2;
  localparam logic [1:0] OP_PEEK   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [WordW-1:0] push_value;
  } mse_req_t;

  typedef struct packed {
    logic signed [WordW-1:0] removed_value;
    logic signed [WordW-1:0] top_value;
    logic signed [WordW-1:0] max_value;
    logic                    is_empty;
    logic [1:0]              op_error;
  } mse_rsp_t;

  // control from the sequencer to the maximum tracker
  typedef struct packed {
    logic clear;
    logic feed;
  } mse_scan_ctl_t;

endpackage

// File: design/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mse_scan.sv
// ----------------------------------------------------------------------------
// mse_scan
// Running maximum over a stream of entries, latest of equal values wins.
// ----------------------------------------------------------------------------
module mse_scan
  import mse_pkg::*;
#(
  parameter int unsigned AddrW = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mse_scan_ctl_t           ctl_i,
  input  logic signed [WordW-1:0] data_i,
  input  logic [AddrW-1:0]        idx_i,
  output logic signed [WordW-1:0] max_o,
  output logic [AddrW-1:0]        idx_o
);

  logic signed [WordW-1:0] best_q, best_d;
  logic [AddrW-1:0]        best_idx_q, best_idx_d;
  logic                    best_vld_q, best_vld_d;
  logic                    take;

  // ties go to the later entry, which sits nearer the top
  assign take = ctl_i.feed && (!best_vld_q || (data_i >= best_q));

  always_comb begin
    best_d     = take ? data_i : best_q;
    best_idx_d = take ? idx_i : best_idx_q;
    best_vld_d = best_vld_q;
    if (ctl_i.clear) begin
      best_vld_d = 1'b0;
    end else if (ctl_i.feed) begin
      best_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
    end else begin
      best_vld_q <= best_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
  end

  assign max_o = best_d;
  assign idx_o = best_idx_d;

endmodule

// File: design/max_stack_engine.sv
// ----------------------------------------------------------------------------
// max_stack_engine
// Bounded stack of signed words with push, pop, pop-maximum and peek.
// ----------------------------------------------------------------------------
// One request is handled at a time; each gives one response. Push, peek, any
// request that ends in an error and any pop that leaves the stack empty go
// from acceptance straight to the response register. Any other pop and
// pop-maximum go through the single-port-read entry memory: first, for a
// pop-maximum, the entries above the removed maximum move down one place to
// close the gap, then every entry left after the pop is read once to find
// the new maximum and top, the last read returning through the registered
// read port. Input stays stalled until the response has moved into the output
// register, so the next request can be accepted in the cycle after that. No
// clearing pass is needed after reset. A new request is taken while a
// response still waits in the output register.
module max_stack_engine
  import mse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  mse_req_t in_req_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output mse_rsp_t out_rsp_o,
  input  logic     out_stall_i
);

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SHIFT  = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic signed [WordW-1:0] top_q, top_d;
  logic signed [WordW-1:0] max_q, max_d;
  logic [AddrW-1:0]        max_idx_q, max_idx_d;
  logic signed [WordW-1:0] removed_q, removed_d;
  logic [1:0]              err_q, err_d;
  logic [AddrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]         scan_ptr_q, scan_ptr_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [AddrW-1:0]        rd_idx_q, rd_idx_d;
  logic                    out_valid_q, out_valid_d;
  mse_rsp_t                out_q, out_d;

  logic                    in_fire;
  logic                    ram_we, ram_re;
  logic [AddrW-1:0]        ram_waddr, ram_raddr;
  logic [WordW-1:0]        ram_wdata, ram_rdata;
  logic signed [WordW-1:0] rdata_s;
  mse_scan_ctl_t           scan_ctl;
  logic signed [WordW-1:0] scan_max;
  logic [AddrW-1:0]        scan_idx;
  logic [CntW-1:0]         count_m1;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign rdata_s    = $signed(ram_rdata);
  assign count_m1   = count_q - CntOne;

  mse_ram #(
    .Width (WordW),
    .Depth (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mse_scan #(
    .AddrW (AddrW)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .data_i (rdata_s),
    .idx_i  (rd_idx_q),
    .max_o  (scan_max),
    .idx_o  (scan_idx)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    top_d      = top_q;
    max_d      = max_q;
    max_idx_d  = max_idx_q;
    removed_d  = removed_q;
    err_d      = err_q;
    wr_ptr_d   = wr_ptr_q;
    scan_ptr_d = scan_ptr_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    ram_we     = 1'b0;
    ram_waddr  = wr_ptr_q;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = scan_ptr_q[AddrW-1:0];
    scan_ctl   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          removed_d  = '0;
          err_d      = ERR_NONE;
          scan_ptr_d = '0;
          scan_ctl.clear = 1'b1;
          state_d    = ST_FINISH;
          case (in_req_i.opcode)
            OP_PUSH: begin
              if (count_q == CntFull) begin
                err_d = ERR_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AddrW-1:0];
                ram_wdata = in_req_i.push_value;
                count_d   = count_q + CntOne;
                top_d     = in_req_i.push_value;
                if ((count_q == '0) || (in_req_i.push_value >= max_q)) begin
                  max_d     = in_req_i.push_value;
                  max_idx_d = count_q[AddrW-1:0];
                end
              end
            end
            OP_POP, OP_POPMAX: begin
              if (count_q == '0) begin
                err_d = ERR_EMPTY;
              end else begin
                count_d   = count_m1;
                removed_d = (in_req_i.opcode == OP_POP) ? top_q : max_q;
                if (count_m1 == '0) begin
                  top_d = '0;
                  max_d = '0;
                end else if ((in_req_i.opcode == OP_POPMAX) &&
                             (CntW'(max_idx_q) != count_m1)) begin
                  // close the gap: read the entry just above the maximum
                  ram_re    = 1'b1;
                  ram_raddr = max_idx_q + AddrW'(1);
                  wr_ptr_d  = max_idx_q;
                  state_d   = ST_SHIFT;
                end else begin
                  state_d = ST_SCAN;
                end
              end
            end
            OP_PEEK: begin
              err_d = ERR_NONE;
            end
            default: begin
              err_d = ERR_NONE;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_q;
        ram_wdata = ram_rdata;
        wr_ptr_d  = wr_ptr_q + AddrW'(1);
        if (CntW'(wr_ptr_q) == count_m1) begin
          state_d = ST_SCAN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wr_ptr_q + AddrW'(2);
        end
      end

      ST_SCAN: begin
        if (scan_ptr_q < count_q) begin
          ram_re     = 1'b1;
          ram_raddr  = scan_ptr_q[AddrW-1:0];
          rd_vld_d   = 1'b1;
          rd_idx_d   = scan_ptr_q[AddrW-1:0];
          scan_ptr_d = scan_ptr_q + CntOne;
        end
        if (rd_vld_q) begin
          scan_ctl.feed = 1'b1;
          if (CntW'(rd_idx_q) == count_m1) begin
            // last entry read is the top
            top_d     = rdata_s;
            max_d     = scan_max;
            max_idx_d = scan_idx;
            rd_vld_d  = 1'b0;
            state_d   = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // response register: load on finish, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_FINISH) && (!out_valid_q || !out_stall_i)) begin
      out_valid_d         = 1'b1;
      out_d.removed_value = removed_q;
      out_d.top_value     = top_q;
      out_d.max_value     = max_q;
      out_d.is_empty      = (count_q == '0);
      out_d.op_error      = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      max_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      max_q       <= max_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_idx_q  <= max_idx_d;
    removed_q  <= removed_d;
    err_q      <= err_d;
    wr_ptr_q   <= wr_ptr_d;
    scan_ptr_q <= scan_ptr_d;
    rd_idx_q   <= rd_idx_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("entry count above stack depth");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && (count_q == '0) |-> (top_q == '0) && (max_q == '0))
    else $error("empty stack with nonzero top or maximum");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !ram_we)
    else $error("memory write during maximum scan");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("sequencer idle right after accepting a request");
`endif

endmodule

// File: tb/max_stack_engine_tb.sv
// ----------------------------------------------------------------------------
// max_stack_engine_tb
// Self-checking bench for the max stack engine. A queue of requests feeds a
// bursty driver, a monitor predicts each accepted request with a local stack
// model and compares every response field in order, and the response side
// stalls on its own pattern, including long hold-offs.
// ----------------------------------------------------------------------------
module max_stack_engine_tb
  import mse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 800;

  typedef struct {
    mse_req_t req;
    bit       drain_first;
  } queued_req_t;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  mse_req_t in_req = '0;
  logic     in_stall;
  logic     out_valid;
  mse_rsp_t out_rsp;
  logic     out_stall = 1'b0;

  queued_req_t pending_reqs[$];
  mse_rsp_t    expected_rsps[$];

  logic signed [WordW-1:0] stack_words[STACK_DEPTH];
  int stack_count = 0;

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  accepted_count = 0;
  bit  req_taken = 1'b0;

  int burst_left = 8;
  int gap_left = 0;

  int hold_left = 0;
  int next_hold_at = 40;
  int stall_mode = 0;
  int mode_left = 20;

  max_stack_engine #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_req_i   (in_req),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_rsp_o  (out_rsp),
    .out_stall_i(out_stall)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // index of the largest entry, nearest the top on ties
  function automatic int max_index();
    int best;
    int i;
    best = 0;
    for (i = 1; i < stack_count; i++) begin
      if (stack_words[i] >= stack_words[best]) best = i;
    end
    return best;
  endfunction

  function automatic mse_rsp_t predict_response(mse_req_t req);
    mse_rsp_t rsp;
    int idx;
    int i;
    rsp = '0;
    case (req.opcode)
      OP_PUSH: begin
        if (stack_count >= STACK_DEPTH) begin
          rsp.op_error = ERR_FULL;
        end else begin
          stack_words[stack_count] = req.push_value;
          stack_count++;
        end
      end
      OP_POP, OP_POPMAX: begin
        if (stack_count == 0) begin
          rsp.op_error = ERR_EMPTY;
        end else if (req.opcode == OP_POP) begin
          stack_count--;
          rsp.removed_value = stack_words[stack_count];
        end else begin
          idx = max_index();
          rsp.removed_value = stack_words[idx];
          // close the gap below the top
          for (i = idx; i + 1 < stack_count; i++) stack_words[i] = stack_words[i + 1];
          stack_count--;
        end
      end
      default: ;
    endcase
    if (stack_count > 0) begin
      rsp.top_value = stack_words[stack_count - 1];
      rsp.max_value = stack_words[max_index()];
    end
    rsp.is_empty = (stack_count == 0);
    return rsp;
  endfunction

  task automatic check_field(string name, logic [WordW-1:0] exp_val, logic [WordW-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // response check first, then prediction of the request taken at this edge
  always @(posedge clk_i) begin
    mse_rsp_t exp_rsp;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t ns: unexpected response, expected none, actual %h", $time, out_rsp);
        mismatch_count++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        check_field("removed_value", exp_rsp.removed_value, out_rsp.removed_value);
        check_field("top_value", exp_rsp.top_value, out_rsp.top_value);
        check_field("max_value", exp_rsp.max_value, out_rsp.max_value);
        check_field("is_empty", WordW'(exp_rsp.is_empty), WordW'(out_rsp.is_empty));
        check_field("op_error", WordW'(exp_rsp.op_error), WordW'(out_rsp.op_error));
      end
    end
    if (rst_ni && in_valid && !in_stall) begin
      expected_rsps.insert(expected_rsps.size(), predict_response(in_req));
      accepted_count <= accepted_count + 1;
      req_taken <= 1'b1;
    end else begin
      req_taken <= 1'b0;
    end
  end

  // request driver: bursts with gaps, hold the payload until taken
  always @(negedge clk_i) begin
    queued_req_t next_item;
    if (rst_ni && (!in_valid || req_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   (!pending_reqs[0].drain_first || expected_rsps.size() == 0)) begin
        next_item = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_req <= next_item.req;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // response stall: long hold-offs at set points, else a changing pattern
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (accepted_count >= next_hold_at) begin
      hold_left = HOLD_CYCLES;
      next_hold_at = next_hold_at + 460;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic add_req(logic [1:0] op, logic [WordW-1:0] value, bit drain_first = 1'b0);
    queued_req_t item;
    item.req.opcode = op;
    item.req.push_value = value;
    item.drain_first = drain_first;
    pending_reqs.insert(pending_reqs.size(), item);
  endtask

  function automatic logic [WordW-1:0] pick_value(int style);
    logic [WordW-1:0] v;
    case (style)
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_op(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return OP_PUSH;
    roll = $urandom_range(0, 99);
    if (roll < 35) return OP_POP;
    if (roll < 80) return OP_POPMAX;
    return OP_PEEK;
  endfunction

  initial begin
    int added;
    int seg_len;
    int push_pct;
    int style;
    int k;

    // empty stack cases
    add_req(OP_POP, 32'h1234_5678);
    add_req(OP_POPMAX, 32'hdead_beef);
    add_req(OP_PEEK, 32'h0);
    // extremes of the value range
    add_req(OP_PUSH, 32'h7fff_ffff);
    add_req(OP_PUSH, 32'h8000_0000);
    add_req(OP_PUSH, 32'h0000_0000);
    add_req(OP_PUSH, 32'hffff_ffff);
    add_req(OP_PEEK, 32'hffff_ffff);
    add_req(OP_POPMAX, 32'h0);
    add_req(OP_POP, 32'h0);
    add_req(OP_POP, 32'h0);
    add_req(OP_POP, 32'h0);
    add_req(OP_POP, 32'h0);
    // tie for the maximum: the upper one must go, order shows on the pops
    add_req(OP_PUSH, 32'd7);
    add_req(OP_PUSH, 32'd2);
    add_req(OP_PUSH, 32'd7);
    add_req(OP_PUSH, 32'd1);
    add_req(OP_POPMAX, 32'h0);
    add_req(OP_POP, 32'h0);
    add_req(OP_POP, 32'h0);
    add_req(OP_POP, 32'h0);
    add_req(OP_PUSH, -32'sd5);
    add_req(OP_PUSH, -32'sd5);
    add_req(OP_POPMAX, 32'h0);
    add_req(OP_POPMAX, 32'h0);

    // fill past full after a drain, then peel with deep pop-maximum
    added = 0;
    for (k = 0; k < STACK_DEPTH + 3; k++) begin
      add_req(OP_PUSH, pick_value($urandom_range(0, 2)), k == 0);
      added++;
    end
    for (k = 0; k < 30; k++) begin
      add_req(($urandom_range(0, 3) == 0) ? OP_PEEK : OP_POPMAX, $urandom);
      added++;
    end

    while (added < RANDOM_ITEMS) begin
      seg_len = $urandom_range(30, 120);
      case ($urandom_range(0, 2))
        0: push_pct = 25;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      style = $urandom_range(0, 2);
      for (k = 0; k < seg_len; k++) begin
        add_req(pick_op(push_pct),
                ($urandom_range(0, 9) == 0) ? pick_value(2) : pick_value(style),
                (k == 0) && ($urandom_range(0, 2) == 0));
        added++;
      end
    end

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    while ((pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0) &&
           cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
    end

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule
